// File: design/ecs_pkg.sv
`default_nettype none

package ecs_pkg;

    localparam int LEVEL_BITS = 32;
    localparam int CNT_BITS   = 15;
    localparam int PROD_BITS  = LEVEL_BITS + 16;
    localparam int DIV_SHIFT  = 15;

    localparam int          SHIFT_KNEE = 11;
    localparam int          EXP_KNEE   = 'h6000;
    localparam logic [15:0] INC_FULL   = 16'h8000;
    localparam logic [3:0]  INC_BASE   = 4'd7;
    localparam logic [3:0]  DEC_BASE   = 4'd8;

    typedef struct packed {
        logic [4:0] rate_shift;
        logic [1:0] rate_step;
        logic       is_decrease;
        logic       is_exponential;
        logic       invert_sign;
    } t_ecs_in;

    typedef struct packed {
        logic              step_fired;
        logic signed [31:0] new_level;
    } t_ecs_out;

endpackage

`default_nettype wire

// File: design/ecs_step.sv
`default_nettype none

module ecs_step import ecs_pkg::*; (
    input  t_ecs_in                       i_item,
    input  logic signed [LEVEL_BITS-1:0]  i_level,
    input  logic        [CNT_BITS-1:0]    i_count,
    output logic signed [LEVEL_BITS-1:0]  o_level,
    output logic        [CNT_BITS-1:0]    o_count,
    output logic                          o_fired
);

    localparam logic signed [PROD_BITS-1:0] PROD_BIAS = PROD_BITS'((1 << DIV_SHIFT) - 1);

    logic        [4:0]             inc_sh;
    logic        [3:0]             stp_sh;
    logic        [15:0]            inc;
    logic        [15:0]            inc_adj;
    logic        [15:0]            sum;
    logic        [3:0]             base;
    logic        [14:0]            mag;
    logic signed [15:0]            step16;
    logic signed [PROD_BITS-1:0]   prod;
    logic signed [PROD_BITS-1:0]   biased;
    logic        [LEVEL_BITS:0]    quot;
    logic signed [LEVEL_BITS-1:0]  exp_step;
    logic signed [LEVEL_BITS-1:0]  lin_step;
    logic signed [LEVEL_BITS-1:0]  sel_step;
    logic signed [LEVEL_BITS-1:0]  fin_step;

    always_comb begin
        inc_sh = (i_item.rate_shift > 5'(SHIFT_KNEE)) ?
                 5'(i_item.rate_shift - 5'(SHIFT_KNEE)) : '0;
        stp_sh = (i_item.rate_shift < 5'(SHIFT_KNEE)) ?
                 4'(5'(SHIFT_KNEE) - i_item.rate_shift) : '0;
        inc    = INC_FULL >> inc_sh;
        // exponential rise slows above the knee
        if (i_item.is_exponential && !i_item.is_decrease && (i_level > EXP_KNEE)) begin
            inc_adj = inc >> 2;
        end else begin
            inc_adj = inc;
        end
        sum     = {1'b0, i_count} + inc_adj;
        o_fired = sum[15];
        o_count = sum[CNT_BITS-1:0];

        base   = i_item.is_decrease ? (DEC_BASE - {2'b00, i_item.rate_step})
                                    : (INC_BASE - {2'b00, i_item.rate_step});
        mag    = 15'(base) << stp_sh;
        step16 = i_item.is_decrease ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

        // scale by level/32768, truncating toward zero
        prod   = step16 * i_level;
        biased = prod[PROD_BITS-1] ? (prod + PROD_BIAS) : prod;
        quot   = biased[PROD_BITS-1:DIV_SHIFT];
        if ((quot == '0) && (i_level > 0)) begin
            exp_step = '1;
        end else begin
            exp_step = LEVEL_BITS'(quot);
        end
        lin_step = LEVEL_BITS'(step16);

        sel_step = (i_item.is_exponential && i_item.is_decrease) ? exp_step : lin_step;
        fin_step = i_item.invert_sign ? -sel_step : sel_step;
        o_level  = o_fired ? (i_level + fin_step) : i_level;
    end

endmodule

`default_nettype wire

// File: design/envelope_counter_step_core.sv
// The input beat passes through an input register and a result register.
// Throughput: one tick per cycle while i_stall is low; the level/counter update is
// combinational through a 16x32 multiply, a rounding add, a negate and the level add.
// Reset (i_rst_n low, synchronous): level and rate counter cleared, both stages empty.
`default_nettype none

module envelope_counter_step_core import ecs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_ecs_in  i_data,
    output logic     o_valid,
    input  logic     i_stall,
    output t_ecs_out o_data
);

    logic                          r_in_valid;
    t_ecs_in                       r_in;
    logic signed [LEVEL_BITS-1:0]  r_level;
    logic        [CNT_BITS-1:0]    r_count;
    logic                          r_out_valid;
    t_ecs_out                      r_out;

    logic signed [LEVEL_BITS-1:0]  n_level;
    logic        [CNT_BITS-1:0]    n_count;
    logic                          n_fired;
    logic                          adv;

    ecs_step u_step (
        .i_item  (r_in),
        .i_level (r_level),
        .i_count (r_count),
        .o_level (n_level),
        .o_count (n_count),
        .o_fired (n_fired)
    );

    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !adv;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_level     <= '0;
            r_count     <= '0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            if (r_in_valid && adv) begin
                r_level <= n_level;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_data;
        end
        if (r_in_valid && adv) begin
            r_out.step_fired <= n_fired;
            r_out.new_level  <= 32'(n_level);
        end
    end

endmodule

`default_nettype wire

// File: tb/ecs_scoreboard.sv
`timescale 1ns / 100ps

module ecs_scoreboard import ecs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_stall,
    input  t_ecs_in  i_in_data,
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_ecs_out i_out_data,
    output int       o_pending,
    output int       o_fail_count
);

    logic signed [LEVEL_BITS-1:0] env_level;
    logic [CNT_BITS-1:0]          rate_count;
    t_ecs_out                     expected_env[$];
    int                           fault_count = 0;

    task automatic report_fault(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
        fault_count++;
    endtask

    // Advances the envelope by one tick and returns the beat it should produce.
    function automatic t_ecs_out next_envelope(input t_ecs_in t);
        longint      lvl;
        longint      step;
        longint      sum_lvl;
        int          sh;
        int          inc_sh;
        int          stp_sh;
        logic [16:0] inc;
        logic [16:0] sum;
        t_ecs_out    r;
        lvl    = env_level;
        sh     = int'(t.rate_shift);
        inc_sh = (sh > SHIFT_KNEE) ? sh - SHIFT_KNEE : 0;
        stp_sh = (sh < SHIFT_KNEE) ? SHIFT_KNEE - sh : 0;
        inc    = {1'b0, INC_FULL} >> inc_sh;
        step   = t.is_decrease ? longint'(DEC_BASE - 4'(t.rate_step))
                               : longint'(INC_BASE - 4'(t.rate_step));
        step   = step <<< stp_sh;
        if (t.is_decrease)
            step = -step;
        // exponential attack slows above the knee
        if (t.is_exponential && !t.is_decrease && lvl > EXP_KNEE)
            inc = inc >> 2;
        sum          = {2'b00, rate_count} + inc;
        rate_count   = sum[CNT_BITS-1:0];
        r.step_fired = sum[15];
        if (sum[15]) begin
            if (t.is_exponential && t.is_decrease) begin
                step = (step * lvl) / (longint'(1) <<< DIV_SHIFT);
                if (step == 0 && lvl > 0)
                    step = -1;
            end
            if (t.invert_sign)
                step = -step;
            sum_lvl   = lvl + step;
            env_level = sum_lvl[LEVEL_BITS-1:0];
        end
        r.new_level = env_level;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_ecs_out want;
        if (!i_rst_n) begin
            env_level  = '0;
            rate_count = '0;
            expected_env.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                expected_env.push_back(next_envelope(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (expected_env.size() == 0) begin
                    report_fault("unexpected result beat", i_out_data.new_level, '0);
                end else begin
                    want = expected_env.pop_front();
                    if (i_out_data.step_fired !== want.step_fired)
                        report_fault("step_fired", 32'(i_out_data.step_fired),
                                     32'(want.step_fired));
                    if (i_out_data.new_level !== want.new_level)
                        report_fault("new_level", i_out_data.new_level, want.new_level);
                end
            end
        end
        o_pending    <= expected_env.size();
        o_fail_count <= fault_count;
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb import ecs_pkg::*; ();

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_TICKS = 1900;

    typedef enum {EP_NOISE, EP_ATTACK, EP_DECAY, EP_SWELL, EP_FALL, EP_SLOW} t_episode;
    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     i_stall = 1'b0;
    t_ecs_in  i_data  = '0;
    logic     o_stall;
    logic     o_valid;
    t_ecs_out o_data;

    int          pending;
    int          fail_count;
    int unsigned cycles     = 0;
    int          burst_left = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_left = 0;

    envelope_counter_step_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    ecs_scoreboard u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_data   (o_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:     i_stall <= 1'b0;
            STALL_LIGHT:    i_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    i_stall <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: i_stall <= (stall_left[3:0] < 4'd5);
            default:        i_stall <= 1'b0;
        endcase
    end

    function automatic t_ecs_in make_tick(input int sh, input int idx, input int dec,
                                          input int expo, input int inv);
        t_ecs_in t;
        t.rate_shift     = 5'(sh);
        t.rate_step      = 2'(idx);
        t.is_decrease    = 1'(dec);
        t.is_exponential = 1'(expo);
        t.invert_sign    = 1'(inv);
        return t;
    endfunction

    function automatic t_ecs_in random_tick(input t_episode ep);
        t_ecs_in t;
        t = make_tick($urandom_range(0, 31), $urandom_range(0, 3), $urandom_range(0, 1),
                      $urandom_range(0, 1), $urandom_range(0, 1));
        case (ep)
            EP_ATTACK: begin
                t.rate_shift  = 5'($urandom_range(0, 14));
                t.is_decrease = 1'b0;
                t.invert_sign = 1'b0;
            end
            EP_DECAY: begin
                t.rate_shift     = 5'($urandom_range(0, 14));
                t.is_decrease    = 1'b1;
                t.is_exponential = 1'b1;
                t.invert_sign    = 1'b0;
            end
            EP_SWELL: begin
                // inverted exponential decrease grows geometrically and wraps
                t.rate_shift     = 5'($urandom_range(0, 11));
                t.is_decrease    = 1'b1;
                t.is_exponential = 1'b1;
                t.invert_sign    = 1'b1;
            end
            EP_FALL: begin
                t.rate_shift     = 5'($urandom_range(0, 13));
                t.is_decrease    = 1'b1;
                t.is_exponential = 1'b0;
            end
            EP_SLOW:  t.rate_shift = 5'($urandom_range(11, 31));
            default: ;
        endcase
        return t;
    endfunction

    task automatic issue_tick(input t_ecs_in tick);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap        = $urandom_range(0, 9);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_data  <= tick;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    initial begin
        t_episode ep;
        int       ep_left;
        ep_left = 0;
        ep      = EP_NOISE;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero level under exponential decay, then linear attack past the knee
        issue_tick(make_tick(11, 0, 1, 1, 0));
        issue_tick(make_tick(0, 0, 0, 0, 0));
        issue_tick(make_tick(0, 0, 0, 0, 0));
        // exponential attack above the knee: counter quartered
        issue_tick(make_tick(11, 0, 0, 1, 0));
        issue_tick(make_tick(11, 1, 0, 1, 0));
        issue_tick(make_tick(11, 2, 0, 1, 0));
        issue_tick(make_tick(11, 3, 0, 1, 0));
        // counter never moves at shifts of 27 and above
        issue_tick(make_tick(31, 3, 1, 1, 1));
        issue_tick(make_tick(27, 2, 0, 0, 0));
        issue_tick(make_tick(26, 1, 0, 0, 0));
        issue_tick(make_tick(12, 1, 0, 0, 0));
        issue_tick(make_tick(12, 1, 0, 0, 0));
        issue_tick(make_tick(0, 3, 1, 0, 0));
        issue_tick(make_tick(5, 1, 1, 1, 0));
        issue_tick(make_tick(10, 2, 1, 1, 0));
        issue_tick(make_tick(0, 0, 1, 0, 0));
        issue_tick(make_tick(0, 0, 1, 0, 0));
        issue_tick(make_tick(0, 0, 1, 0, 1));
        issue_tick(make_tick(3, 3, 0, 0, 1));
        issue_tick(make_tick(0, 0, 1, 1, 1));
        issue_tick(make_tick(11, 3, 1, 1, 0));
        issue_tick(make_tick(11, 3, 1, 1, 0));
        issue_tick(make_tick(0, 0, 1, 0, 0));
        issue_tick(make_tick(0, 0, 1, 1, 0));

        for (int n = 0; n < RANDOM_TICKS; n++) begin
            if (ep_left == 0) begin
                ep      = t_episode'($urandom_range(0, 5));
                ep_left = $urandom_range(10, 80);
            end
            ep_left--;
            issue_tick(random_tick(ep));
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
